// ===== design/thread_id_deque_core_macros.svh =====
// Assertion macros shared by the thread ID deque RTL.
// Used by thread_id_deque_core; no other dependencies.
`ifndef THREAD_ID_DEQUE_CORE_MACROS_SVH
`define THREAD_ID_DEQUE_CORE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TDQ_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define TDQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tdq_pkg.sv =====
// Package for the thread ID deque: defaults, operation and status codes,
// and the control word broadcast to the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 8;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // One-hot (or all zero) command to every cell for the current word.
    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic take_front;
        logic take_back;
        logic remove;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== design/tdq_cell.sv =====
// One position of the deque chain: holds one ID and its valid bit, and
// shifts toward either neighbor on command. Depends on tdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdq_cell #(
    parameter int ID_WIDTH = tdq_pkg::ID_WIDTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire tdq_pkg::ctrl_t ctrl,
    input  wire  [ID_WIDTH-1:0] id,
    input  wire  [ID_WIDTH-1:0] left_data,
    input  wire                 left_valid,
    input  wire  [ID_WIDTH-1:0] right_data,
    input  wire                 right_valid,
    input  wire                 match_in,
    output logic [ID_WIDTH-1:0] data,
    output logic                valid,
    output logic                match_out
);

    logic [ID_WIDTH-1:0] data_reg;
    logic [ID_WIDTH-1:0] data_next;
    logic                valid_reg;
    logic                valid_next;

    // match_out is set when this cell or any cell ahead of it holds the ID.
    assign match_out = match_in | (valid_reg & (data_reg == id));
    assign data      = data_reg;
    assign valid     = valid_reg;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.ins_front) begin
            data_next  = left_data;
            valid_next = left_valid;
        end else if (ctrl.ins_back && !valid_reg && left_valid) begin
            data_next  = id;
            valid_next = 1'b1;
        end else if (ctrl.take_front) begin
            data_next  = right_data;
            valid_next = right_valid;
        end else if (ctrl.take_back && valid_reg && !right_valid) begin
            valid_next = 1'b0;
        end else if (ctrl.remove && match_out) begin
            data_next  = right_data;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== design/thread_id_deque_core.sv =====
// Thread ID deque: a chain of tdq_cell positions, front at cell 0, with
// the sequencing and the result register. Depends on tdq_pkg, tdq_cell
// and thread_id_deque_core_macros.svh.
//
// Usage:
// The input stream carries one operation per word: push front, push back,
// pop front, pop back, remove first match, or query (codes six and seven
// act as query). The output stream returns exactly one word per input
// word, in order, with the popped ID, a status code, the entry count and
// the front and back IDs after the operation, plus an empty flag.
// Acceptance is followed by the execute state, in which all cells shift at
// once, and the result-gather state, which registers m_tdata and raises
// m_tvalid. A new word can be accepted in the cycle its predecessor's
// result is registered, but not while that predecessor executes.
// Reset clears the count and every cell's valid bit; the queue is empty.
// A stalled receiver holds the result word; one more input word is taken
// and executed, then s_tready stays low until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "thread_id_deque_core_macros.svh"

module thread_id_deque_core #(
    parameter int DEPTH    = tdq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = tdq_pkg::ID_WIDTH_DEF,
    parameter int CNT_W    = $clog2(DEPTH + 1),
    parameter int S_TDATA_W = ((tdq_pkg::OP_W + ID_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W = ((3 * ID_WIDTH + tdq_pkg::STATUS_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // operation, thread_id
    input  wire  [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // popped_id, status, entry_total, front_id, back_id, is_empty
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int M_FIELDS_W = 3 * ID_WIDTH + tdq_pkg::STATUS_W + CNT_W + 1;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [tdq_pkg::OP_W-1:0] op_reg;
    logic [ID_WIDTH-1:0]      id_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [ID_WIDTH-1:0]      popped_reg;
    logic [ID_WIDTH-1:0]      popped_next;
    logic [tdq_pkg::STATUS_W-1:0] status_reg;
    logic [tdq_pkg::STATUS_W-1:0] status_next;
    logic                     m_tvalid_reg;
    logic [M_FIELDS_W-1:0]    m_fields_reg;

    tdq_pkg::ctrl_t ctrl;

    logic [ID_WIDTH-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    cell_match;

    logic                s_accept;
    logic                out_free;
    logic                is_full;
    logic                is_empty;
    logic                found;
    logic [ID_WIDTH-1:0] front_id;
    logic [ID_WIDTH-1:0] back_id;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_fields_reg);

    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign found    = cell_match[DEPTH-1];

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ID_WIDTH-1:0] left_data;
        logic                left_valid;
        logic [ID_WIDTH-1:0] right_data;
        logic                right_valid;
        logic                match_in;

        if (i == 0) begin : g_head
            // A push at the front enters the chain from the left of cell 0.
            assign left_data  = id_reg;
            assign left_valid = 1'b1;
            assign match_in   = 1'b0;
        end else begin : g_body
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
            assign match_in   = cell_match[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        tdq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .id          (id_reg),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .match_in    (match_in),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .match_out   (cell_match[i])
        );
    end

    // The back entry is the only valid cell whose right neighbor is empty.
    always_comb begin
        front_id = cell_valid[0] ? cell_data[0] : '0;
        back_id  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH])) begin
                back_id = back_id | cell_data[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Operation decode
    // ---------------------------------------------------------------
    always_comb begin
        ctrl        = '0;
        cnt_next    = cnt_reg;
        popped_next = '0;
        status_next = tdq_pkg::ST_OK;
        if (state_reg == S_EXEC) begin
            unique case (op_reg) inside
                tdq_pkg::OP_PUSH_FRONT,
                tdq_pkg::OP_PUSH_BACK: begin
                    if (is_full) begin
                        status_next = tdq_pkg::ST_PUSH_FULL;
                    end else begin
                        ctrl.ins_front = (op_reg == tdq_pkg::OP_PUSH_FRONT);
                        ctrl.ins_back  = (op_reg == tdq_pkg::OP_PUSH_BACK);
                        cnt_next       = cnt_reg + CNT_W'(1);
                    end
                end
                tdq_pkg::OP_POP_FRONT,
                tdq_pkg::OP_POP_BACK: begin
                    if (is_empty) begin
                        status_next = tdq_pkg::ST_POP_EMPTY;
                    end else begin
                        ctrl.take_front = (op_reg == tdq_pkg::OP_POP_FRONT);
                        ctrl.take_back  = (op_reg == tdq_pkg::OP_POP_BACK);
                        popped_next     = (op_reg == tdq_pkg::OP_POP_FRONT) ? front_id
                                                                             : back_id;
                        cnt_next        = cnt_reg - CNT_W'(1);
                    end
                end
                tdq_pkg::OP_REMOVE: begin
                    if (found) begin
                        ctrl.remove = 1'b1;
                        cnt_next    = cnt_reg - CNT_W'(1);
                    end else begin
                        status_next = tdq_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == S_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg <= s_tdata[tdq_pkg::OP_W-1:0];
            id_reg <= s_tdata[tdq_pkg::OP_W +: ID_WIDTH];
        end
        if (state_reg == S_EXEC) begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
        // The cells already hold the updated queue during the gather cycle.
        if ((state_reg == S_DONE) && out_free) begin
            m_fields_reg <= {is_empty, back_id, front_id, cnt_reg, status_reg, popped_reg};
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TDQ_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, cnt_reg <= CNT_W'(DEPTH), "count above depth")
    `TDQ_ASSERT_ALWAYS(a_count_valid, aclk, aresetn, $countones(cell_valid) == int'(cnt_reg), "valid bits disagree with count")
    `TDQ_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_accept, state_reg == S_EXEC, "accepted word not executed")

endmodule

`default_nettype wire
